// File: hw/rtl/rbd_pkg.sv
// Package for the ring buffer deque: sizes, opcode codes, status structs
// and the ring pointer helper. Depends on nothing.
package rbd_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   // Fixed widths of the channel fields
   localparam int OPCODE_W   = 3;
   localparam int WORD_W     = 32;
   localparam int POSITION_W = 5;
   localparam int COUNT_W    = 5;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   // Compare width for signed position against count, one spare bit
   localparam int CMP_W = ((CNT_W > POSITION_W) ? CNT_W : POSITION_W) + 1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_POP_BACK   = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_READ_INDEX = 3'd6,
      OP_CLEAR      = 3'd7
   } op_type;

   // Store access for the current word
   typedef struct packed {
      logic             we;
      logic [PTR_W-1:0] waddr;
      logic             re;
      logic [PTR_W-1:0] raddr;
   } ram_ctl_type;

   // Status of the current word, captured into the result register
   typedef struct packed {
      logic             ok;
      logic             rd_sel;
      logic [CNT_W-1:0] count;
   } step_type;

   // (head + off) mod DEPTH, correct only while off does not exceed DEPTH
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

// File: hw/rtl/rbd_if.sv
// Handshake interfaces for the deque's request and response channels.
// Depends on rbd_pkg for field widths.
interface rbd_req_if import rbd_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [OPCODE_W-1:0]          opcode;
   logic [WORD_W-1:0]            data_in;
   logic signed [POSITION_W-1:0] position;

   modport source (output valid, opcode, data_in, position, input ready);
   modport sink   (input valid, opcode, data_in, position, output ready);
endinterface

interface rbd_rsp_if import rbd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ok;
   logic [WORD_W-1:0]  read_data;
   logic [COUNT_W-1:0] count;
   logic               is_empty;

   modport source (output valid, ok, read_data, count, is_empty, input ready);
   modport sink   (input valid, ok, read_data, count, is_empty, output ready);
endinterface

// File: hw/rtl/rbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];  // read-first
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/rbd_ctrl.sv
// Head pointer and element count of the deque, opcode decode and store
// addressing. Depends on rbd_pkg.
module rbd_ctrl import rbd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [OPCODE_W-1:0]          opcode,
   input  logic signed [POSITION_W-1:0] position,
   output ram_ctl_type                  ram_ctl,
   output step_type                     step
);

   logic [PTR_W-1:0] head_ff, head_in, head_nx;
   logic [CNT_W-1:0] count_ff, count_in, count_nx;
   logic             full, empty;
   logic             ok, rd_sel, we;
   logic [PTR_W-1:0] waddr, raddr;
   logic [CMP_W-1:0] pos_w, cnt_w, mag, off_w;
   logic             in_range;
   op_type           op;

   assign op    = op_type'(opcode);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // Signed index: non-negative from the front, negative from the back
   always_comb begin
      pos_w = CMP_W'(position);
      cnt_w = CMP_W'(count_ff);
      mag   = CMP_W'(0) - pos_w;
      if (!position[POSITION_W-1]) begin
         in_range = (pos_w < cnt_w);
         off_w    = pos_w;
      end else begin
         in_range = (mag <= cnt_w);
         off_w    = cnt_w - mag;
      end
   end

   always_comb begin
      head_nx  = head_ff;
      count_nx = count_ff;
      ok       = 1'b0;
      rd_sel   = 1'b0;
      we       = 1'b0;
      waddr    = wrap_add(head_ff, count_ff);
      raddr    = head_ff;
      unique case (op)
         OP_PUSH_BACK: begin
            if (!full) begin
               we       = 1'b1;
               count_nx = count_ff + 1'b1;
               ok       = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (!empty) begin
               count_nx = count_ff - 1'b1;
               ok       = 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            if (!full) begin
               head_nx  = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - 1'b1;
               waddr    = head_nx;
               we       = 1'b1;
               count_nx = count_ff + 1'b1;
               ok       = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (!empty) begin
               head_nx  = wrap_add(head_ff, CNT_W'(1));
               count_nx = count_ff - 1'b1;
               ok       = 1'b1;
            end
         end
         OP_PEEK_FRONT: begin
            ok     = !empty;
            rd_sel = !empty;
         end
         OP_PEEK_BACK: begin
            raddr  = wrap_add(head_ff, count_ff - 1'b1);
            ok     = !empty;
            rd_sel = !empty;
         end
         OP_READ_INDEX: begin
            raddr  = wrap_add(head_ff, off_w[CNT_W-1:0]);
            ok     = in_range;
            rd_sel = in_range;
         end
         OP_CLEAR: begin
            head_nx  = '0;
            count_nx = '0;
            ok       = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign head_in  = accept ? head_nx  : head_ff;
   assign count_in = accept ? count_nx : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign ram_ctl.we    = accept && we;
   assign ram_ctl.waddr = waddr;
   assign ram_ctl.re    = accept;
   assign ram_ctl.raddr = raddr;

   assign step.ok     = ok;
   assign step.rd_sel = rd_sel;
   assign step.count  = count_nx;

endmodule

// File: hw/rtl/ring_buffer_deque_core.sv
// Top level of the ring buffer deque: request/response handshake, result
// register and ring store. Depends on rbd_pkg, rbd_if, rbd_ram, rbd_ctrl.
//
// Usage
//  - req_port carries one operation per word: opcode, data_in (pushes),
//    position (signed read index; -1 is the last element).
//  - rsp_port returns exactly one word per request, in order: ok,
//    read_data (peeks and index reads, else zero), count and is_empty
//    after the operation.
//  - The response is registered: it is valid in the cycle after the request is taken.
//    Throughput: one request per cycle while responses are taken, limited by
//    the single result register and the ring store's one-read, one-write port.
//  - Head pointer and count update at the accepting edge, so the next
//    request sees them at once; a word written by a push is readable by
//    the very next request.
//  - Stall: while a response waits and rsp_port.ready is low, req_port
//    ready drops. The RAM read register is not re-enabled, so the pending
//    read_data holds. When the response is taken, a new request can enter
//    in the same cycle.
//  - Reset (synchronous, active high) empties the deque and drops the
//    pending response. Store contents are not cleared; only live slots ever
//    reach read_data.
module ring_buffer_deque_core import rbd_pkg::*; (
   input logic   clock,
   input logic   reset,
   rbd_req_if.sink   req_port,
   rbd_rsp_if.source rsp_port
);

   logic                  accept;
   ram_ctl_type           ram_ctl;
   step_type              step;
   logic [63:0]           wdata_wide;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic [63:0]           rdata_wide;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  ok_ff;
   logic                  rd_sel_ff;
   logic [CNT_W-1:0]      count_ff;

   // Free slot in the result register, or it empties this cycle
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;

   rbd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .opcode   (req_port.opcode),
      .position (req_port.position),
      .ram_ctl  (ram_ctl),
      .step     (step)
   );

   assign wdata_wide = 64'(req_port.data_in);

   rbd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_ctl.waddr),
      .wdata (wdata_wide[DATA_WIDTH-1:0]),
      .re    (ram_ctl.re),
      .raddr (ram_ctl.raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, loaded only on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff     <= step.ok;
         rd_sel_ff <= step.rd_sel;
         count_ff  <= step.count;
      end
   end

   // read_data is zero unless a peek or index read hit a live slot
   assign rdata_wide = 64'(ram_rdata);

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.ok        = ok_ff;
   assign rsp_port.read_data = rd_sel_ff ? rdata_wide[WORD_W-1:0] : '0;
   assign rsp_port.count     = COUNT_W'(count_ff);
   assign rsp_port.is_empty  = (count_ff == '0);

endmodule

// File: hw/rtl/rbd_checker.sv
// Port-level checks for ring_buffer_deque_core, attached by bind.
// Depends on rbd_pkg.
module rbd_checker import rbd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_ok,
   input logic [WORD_W-1:0]  rsp_read_data,
   input logic [COUNT_W-1:0] rsp_count,
   input logic               rsp_is_empty
);

   // every taken request shows up as a response on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("no response after accepted request");

   // a stalled response keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data)
                                     && $stable(rsp_count) && $stable(rsp_ok)))
      else $error("stalled response changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("is_empty disagrees with count");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= COUNT_W'(DEPTH)))
      else $error("count above capacity");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_read_data == '0))
      else $error("failed operation returned data");

endmodule

bind ring_buffer_deque_core rbd_checker u_rbd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_port.valid),
   .req_ready     (req_port.ready),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .rsp_ok        (rsp_port.ok),
   .rsp_read_data (rsp_port.read_data),
   .rsp_count     (rsp_port.count),
   .rsp_is_empty  (rsp_port.is_empty)
);

// File: sim/ring_buffer_deque_core_tb.sv
// Self-checking testbench for ring_buffer_deque_core: directed corner words, then biased
// random traffic with random idling on both channels, checked against an in-bench deque.
// Depends on rbd_pkg, rbd_if (rbd_req_if, rbd_rsp_if) and the ring_buffer_deque_core RTL.
module ring_buffer_deque_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rbd_pkg::*;

   localparam int RANDOM_WORDS   = 450;
   localparam int HOLD_OFF_AT    = 200;   // response index where the long back-pressure starts
   localparam int HOLD_OFF_LEN   = 80;    // cycles of rsp ready low, far beyond one slot of slack
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either channel
   localparam int DRAIN_CYCLES   = 4;     // spare cycles waited after the last response is checked

   // One response word as the block reports it
   typedef struct packed {
      logic               ok;
      logic [WORD_W-1:0]  read_data;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
   } deque_rsp_type;

   // Tracks the deque contents and queues the expected response for every accepted request.
   class deque_scoreboard;
      logic [WORD_W-1:0] slots [DEPTH];
      logic [PTR_W-1:0]  head;
      int                live;
      deque_rsp_type     due_q [$];
      int                errors;
      int                checked;
      int                full_pushes;
      int                empty_pops;
      int                missed_reads;

      function new();
         head         = '0;
         live         = 0;
         errors       = 0;
         checked      = 0;
         full_pushes  = 0;
         empty_pops   = 0;
         missed_reads = 0;
      endfunction

      function void note_request(op_type op, logic [WORD_W-1:0] word,
                                 logic signed [POSITION_W-1:0] pos);
         deque_rsp_type r;
         int            p;
         r = '0;
         p = pos;  // sign-extended
         case (op)
            OP_PUSH_BACK: begin
               if (live < DEPTH) begin
                  slots[PTR_W'(int'(head) + live)] = word;
                  live++;
                  r.ok = 1'b1;
               end else full_pushes++;
            end
            OP_POP_BACK: begin
               if (live > 0) begin
                  live--;
                  r.ok = 1'b1;
               end else empty_pops++;
            end
            OP_PUSH_FRONT: begin
               if (live < DEPTH) begin
                  head = head - 1'b1;
                  slots[head] = word;
                  live++;
                  r.ok = 1'b1;
               end else full_pushes++;
            end
            OP_POP_FRONT: begin
               if (live > 0) begin
                  head = head + 1'b1;
                  live--;
                  r.ok = 1'b1;
               end else empty_pops++;
            end
            OP_PEEK_FRONT: begin
               if (live > 0) begin
                  r.read_data = slots[head];
                  r.ok = 1'b1;
               end else missed_reads++;
            end
            OP_PEEK_BACK: begin
               if (live > 0) begin
                  r.read_data = slots[PTR_W'(int'(head) + live - 1)];
                  r.ok = 1'b1;
               end else missed_reads++;
            end
            OP_READ_INDEX: begin
               if (p >= 0 && p < live) begin
                  r.read_data = slots[PTR_W'(int'(head) + p)];
                  r.ok = 1'b1;
               end else if (p < 0 && -p <= live) begin
                  r.read_data = slots[PTR_W'(int'(head) + live + p)];
                  r.ok = 1'b1;
               end else missed_reads++;
            end
            default: begin  // clear
               head = '0;
               live = 0;
               r.ok = 1'b1;
            end
         endcase
         r.count    = COUNT_W'(live);
         r.is_empty = (live == 0);
         due_q = {due_q, r};
      endfunction

      function void compare_field(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
         end
      endfunction

      function void check_response(deque_rsp_type got);
         deque_rsp_type want;
         if (due_q.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, expected none actual %h", $time, got);
            return;
         end
         want = due_q[0];
         due_q.delete(0);
         checked++;
         compare_field("ok", WORD_W'(want.ok), WORD_W'(got.ok));
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("count", WORD_W'(want.count), WORD_W'(got.count));
         compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   rbd_req_if req_bus ();
   rbd_rsp_if rsp_bus ();

   ring_buffer_deque_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus.sink),
      .rsp_port (rsp_bus.source)
   );

   deque_scoreboard sb = new();
   int sent     = 0;   // request words accepted
   int received = 0;   // response words accepted

   always #5 clock = ~clock;

   // Drive one request word. Called at a falling edge, returns at a falling edge with
   // valid still high, so a back-to-back word never drops valid within one step.
   // Every third stretch of 41 words goes with no gaps at all.
   task automatic send_word(op_type op, logic [WORD_W-1:0] word,
                            logic signed [POSITION_W-1:0] pos);
      int gap;
      gap = ((sent / 41) % 3 == 0) ? 0 : $urandom_range(0, 19);
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= op;
      req_bus.data_in  <= word;
      req_bus.position <= pos;
      // sample at the rising edge; inputs are stable since they only move at falling edges
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(op_type'(req_bus.opcode), req_bus.data_in, req_bus.position);
      sent++;
      @(negedge clock);
   endtask

   // Random payload with the all-zero and all-one words showing up often
   function automatic logic [WORD_W-1:0] pick_data();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return WORD_W'($urandom);
   endfunction

   // One random word. Phases of 32 words lean toward filling, draining, or a mix,
   // so the deque runs into both full and empty many times.
   task automatic send_random_word(int idx);
      int     r;
      int     push_lim;
      int     pop_lim;
      int     clear_lim;
      op_type op;
      case ((idx / 32) % 3)
         0:       begin push_lim = 55; pop_lim = 65; clear_lim = 99; end
         1:       begin push_lim = 15; pop_lim = 60; clear_lim = 98; end
         default: begin push_lim = 35; pop_lim = 65; clear_lim = 97; end
      endcase
      r = $urandom_range(0, 99);
      if (r < push_lim)
         op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else if (r < pop_lim)
         op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      else if (r < clear_lim) begin
         case ($urandom_range(0, 3))
            0:       op = OP_PEEK_FRONT;
            1:       op = OP_PEEK_BACK;
            default: op = OP_READ_INDEX;
         endcase
      end else
         op = OP_CLEAR;
      send_word(op, pick_data(), POSITION_W'($urandom_range(0, 31)));
   endtask

   // Stimulus and end of run
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.opcode   = OP_PUSH_BACK;
      req_bus.data_in  = '0;
      req_bus.position = '0;
      rsp_bus.ready    = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty deque: failed pops, zero peeks, out-of-range read
      send_word(OP_POP_BACK, '0, '0);
      send_word(OP_POP_FRONT, '0, '0);
      send_word(OP_PEEK_FRONT, '0, '0);
      send_word(OP_PEEK_BACK, '0, '0);
      send_word(OP_READ_INDEX, '1, -5'sd1);
      // fill from both ends so the head wraps below slot zero
      send_word(OP_PUSH_BACK, '1, '0);
      send_word(OP_PUSH_FRONT, '0, '0);
      for (int i = 2; i < DEPTH; i++)
         send_word((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, WORD_W'($urandom), '0);
      // full deque: rejected pushes, reads at both position extremes
      send_word(OP_PUSH_BACK, '1, '0);
      send_word(OP_PUSH_FRONT, '1, '0);
      send_word(OP_READ_INDEX, '0, 5'sd15);
      send_word(OP_READ_INDEX, '0, -5'sd16);
      send_word(OP_PEEK_FRONT, '0, '0);
      send_word(OP_PEEK_BACK, '0, '0);
      send_word(OP_CLEAR, '0, '0);

      for (int i = 0; i < RANDOM_WORDS; i++)
         send_random_word(i);
      req_bus.valid <= 1'b0;

      // the watchdog catches a response that never arrives
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests and %0d responses checked; %0d pushes hit a full deque,",
               sent, sb.checked, sb.full_pushes);
      $display("%0d pops hit an empty one, %0d peeks or index reads found nothing.",
               sb.empty_pops, sb.missed_reads);
      if (sb.errors == 0)
         $display("ring_buffer_deque_core regression: pass");
      else
         $display("ring_buffer_deque_core regression: fail");
      $finish;
   end

   // Response side: random stalls per word, stall-free stretches, and one long hold-off
   // that fills the result register and pushes back on the request channel.
   initial begin
      int stall;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = ((received / 37) % 3 == 0) ? 0 : $urandom_range(0, 19);
         if (received == HOLD_OFF_AT) stall = HOLD_OFF_LEN;
         repeat (stall) begin
            rsp_bus.ready <= 1'b0;
            @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         sb.check_response('{rsp_bus.ok, rsp_bus.read_data, rsp_bus.count, rsp_bus.is_empty});
         received++;
         @(negedge clock);
      end
   end

   // Watchdog: a run that stops moving is a failure
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle = 0;
         else
            idle++;
         if (idle >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle);
            $display("ring_buffer_deque_core regression: fail");
            $finish;
         end
      end
   end

endmodule

// File: filelist.f
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_if.sv
hw/rtl/rbd_ram.sv
hw/rtl/rbd_ctrl.sv
hw/rtl/ring_buffer_deque_core.sv
hw/rtl/rbd_checker.sv
sim/ring_buffer_deque_core_tb.sv
